// File: rtl/core/dcs_pkg.sv
// Shared types, constants and helpers for the delimiter closure scanner.
// Used by dcs_stack_cell, dcs_scan_ctrl and delimiter_closure_scanner_top.
`timescale 1ns / 1ps

package dcs_pkg;

   // Opener stack geometry
   localparam int StackDepth = 32;
   localparam int CountWidth = $clog2(StackDepth + 1);

   typedef logic [CountWidth-1:0] count_type;
   typedef logic [7:0]            char_type;
   typedef logic [1:0]            opener_code_type;

   // Opener codes held in the stack cells
   localparam opener_code_type OpenBrace   = 2'd0;
   localparam opener_code_type OpenBracket = 2'd1;
   localparam opener_code_type OpenParen   = 2'd2;

   // ASCII characters the scanner reacts to
   localparam char_type ChLBrace    = 8'h7B;
   localparam char_type ChLBracket  = 8'h5B;
   localparam char_type ChLParen    = 8'h28;
   localparam char_type ChRBrace    = 8'h7D;
   localparam char_type ChRBracket  = 8'h5D;
   localparam char_type ChRParen    = 8'h29;
   localparam char_type ChQuote     = 8'h22;
   localparam char_type ChBackslash = 8'h5C;
   localparam char_type ChStar      = 8'h2A;
   localparam char_type ChSlash     = 8'h2F;
   localparam char_type ChNewline   = 8'h0A;
   localparam char_type ChNone      = 8'h00;

   typedef enum logic [1:0] {
      MODE_CODE,
      MODE_STRING,
      MODE_LINE,
      MODE_BLOCK
   } scan_mode_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_PUSH,
      CELL_POP
   } cell_op_type;

   typedef struct packed {
      scan_mode_type mode;
      logic          pending_slash;
      logic          pending_star;
      logic          pending_escape;
   } scan_state_type;

   typedef struct packed {
      logic            push;
      logic            pop;
      logic            overflow;
      opener_code_type code;
   } stack_cmd_type;

   // Map an opener code to its closing character
   function automatic char_type closer_of(opener_code_type code);
      char_type ch;
      case (code)
         OpenBrace:   ch = ChRBrace;
         OpenBracket: ch = ChRBracket;
         OpenParen:   ch = ChRParen;
         default:     ch = ChNone;
      endcase
      return ch;
   endfunction

endpackage

// File: rtl/core/delimiter_closure_scanner_top.sv
// Delimiter closure scanner: one text byte per request, repair suffix at end of text.
// An ordinary request gives no result. After an end-of-text request the drain state and
// then the result register are loaded; results follow one per cycle (up to 34) while the
// result side does not stall, paced by the one-pop-per-cycle drain of the cell chain.
// Throughput: one request per cycle, except that requests stall while the suffix drains,
// including every cycle that the result side stalls.
// Reset: synchronous; clears mode, flags, count and overflow; stack cells are not cleared.
`timescale 1ns / 1ps

module delimiter_closure_scanner_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_text_byte,
   input  logic       req_byte_valid,
   input  logic       req_end_of_text,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_suffix_char,
   output logic       rsp_char_valid,
   output logic       rsp_last_of_run,
   output logic       rsp_depth_overflow
);

   typedef enum logic [2:0] {
      ST_SCAN,
      ST_QUOTE,
      ST_STAR,
      ST_SLASH,
      ST_CLOSE,
      ST_EMPTY
   } drain_state_type;

   drain_state_type          state_ff, state_in;
   dcs_pkg::scan_state_type  scan_ff, scan_in;
   dcs_pkg::count_type       count_ff, count_in;
   logic                     overflow_seen_ff, overflow_seen_in;
   logic                     run_overflow_ff, run_overflow_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   dcs_pkg::char_type        rsp_char_ff, rsp_char_in;
   logic                     rsp_char_valid_ff, rsp_char_valid_in;
   logic                     rsp_last_ff, rsp_last_in;
   logic                     rsp_overflow_ff, rsp_overflow_in;

   dcs_pkg::scan_state_type  scan_nxt;
   dcs_pkg::stack_cmd_type   scan_cmd;
   dcs_pkg::cell_op_type     cell_op;
   dcs_pkg::opener_code_type cell_code [dcs_pkg::StackDepth];

   logic req_accept;
   logic scan_hit;
   logic end_hit;
   logic out_free;
   logic emit;
   logic drain_pop;
   dcs_pkg::scan_mode_type end_mode;

   assign req_stall  = (state_ff != ST_SCAN);
   assign req_accept = req_valid && !req_stall;
   assign scan_hit   = req_accept && req_byte_valid;
   assign end_hit    = req_accept && req_end_of_text;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // Per-byte mode and stack command
   dcs_scan_ctrl u_scan_ctrl (
      .text_byte  (req_text_byte),
      .cur        (scan_ff),
      .stack_count(count_ff),
      .top_code   (cell_code[0]),
      .nxt        (scan_nxt),
      .cmd        (scan_cmd)
   );

   // Opener stack as a chain of cells, top at cell 0
   for (genvar i = 0; i < dcs_pkg::StackDepth; i++) begin : g_cell
      dcs_pkg::opener_code_type above;
      dcs_pkg::opener_code_type below;
      if (i == 0) begin : g_top
         assign above = scan_cmd.code;
      end else begin : g_mid
         assign above = cell_code[i-1];
      end
      if (i == dcs_pkg::StackDepth - 1) begin : g_bottom
         assign below = cell_code[i];
      end else begin : g_inner
         assign below = cell_code[i+1];
      end
      dcs_stack_cell u_cell (
         .clock     (clock),
         .op        (cell_op),
         .above_code(above),
         .below_code(below),
         .code      (cell_code[i])
      );
   end

   // Drain emission and next-state logic
   always_comb begin
      state_in          = state_ff;
      scan_in           = scan_ff;
      overflow_seen_in  = overflow_seen_ff;
      run_overflow_in   = run_overflow_ff;
      rsp_char_in       = rsp_char_ff;
      rsp_char_valid_in = rsp_char_valid_ff;
      rsp_last_in       = rsp_last_ff;
      rsp_overflow_in   = rsp_overflow_ff;
      emit              = 1'b0;
      drain_pop         = 1'b0;
      end_mode          = dcs_pkg::MODE_CODE;

      unique case (state_ff)
         ST_SCAN: begin
            emit = 1'b0;
         end
         ST_QUOTE: begin
            if (out_free) begin
               emit              = 1'b1;
               rsp_char_in       = dcs_pkg::ChQuote;
               rsp_char_valid_in = 1'b1;
               rsp_last_in       = (count_ff == '0);
               state_in          = (count_ff == '0) ? ST_SCAN : ST_CLOSE;
            end
         end
         ST_STAR: begin
            if (out_free) begin
               emit              = 1'b1;
               rsp_char_in       = dcs_pkg::ChStar;
               rsp_char_valid_in = 1'b1;
               rsp_last_in       = 1'b0;
               state_in          = ST_SLASH;
            end
         end
         ST_SLASH: begin
            if (out_free) begin
               emit              = 1'b1;
               rsp_char_in       = dcs_pkg::ChSlash;
               rsp_char_valid_in = 1'b1;
               rsp_last_in       = (count_ff == '0);
               state_in          = (count_ff == '0) ? ST_SCAN : ST_CLOSE;
            end
         end
         ST_CLOSE: begin
            if (out_free) begin
               emit              = 1'b1;
               drain_pop         = 1'b1;
               rsp_char_in       = dcs_pkg::closer_of(cell_code[0]);
               rsp_char_valid_in = 1'b1;
               rsp_last_in       = (count_ff == dcs_pkg::CountWidth'(1));
               state_in          = (count_ff == dcs_pkg::CountWidth'(1)) ? ST_SCAN : ST_CLOSE;
            end
         end
         ST_EMPTY: begin
            if (out_free) begin
               emit              = 1'b1;
               rsp_char_in       = dcs_pkg::ChNone;
               rsp_char_valid_in = 1'b0;
               rsp_last_in       = 1'b1;
               state_in          = ST_SCAN;
            end
         end
         default: begin
            state_in = ST_SCAN;
         end
      endcase

      // Carry the run's overflow flag with each result
      if (emit) begin
         rsp_overflow_in = run_overflow_ff;
      end

      // Choose the cell operation and track the count
      priority if (drain_pop) begin
         cell_op = dcs_pkg::CELL_POP;
      end else if (scan_hit && scan_cmd.push) begin
         cell_op = dcs_pkg::CELL_PUSH;
      end else if (scan_hit && scan_cmd.pop) begin
         cell_op = dcs_pkg::CELL_POP;
      end else begin
         cell_op = dcs_pkg::CELL_HOLD;
      end

      unique case (cell_op)
         dcs_pkg::CELL_PUSH: count_in = count_ff + dcs_pkg::CountWidth'(1);
         dcs_pkg::CELL_POP:  count_in = count_ff - dcs_pkg::CountWidth'(1);
         default:            count_in = count_ff;
      endcase

      // Advance scan state on a byte
      if (scan_hit) begin
         scan_in = scan_nxt;
         if (scan_cmd.overflow) begin
            overflow_seen_in = 1'b1;
         end
      end

      // End of text: latch the suffix plan and clear the scan state
      if (end_hit) begin
         end_mode         = scan_in.mode;
         run_overflow_in  = overflow_seen_in;
         overflow_seen_in = 1'b0;
         scan_in          = '0;
         if (end_mode == dcs_pkg::MODE_STRING) begin
            state_in = ST_QUOTE;
         end else if (end_mode == dcs_pkg::MODE_BLOCK) begin
            state_in = ST_STAR;
         end else if (count_in != '0) begin
            state_in = ST_CLOSE;
         end else begin
            state_in = ST_EMPTY;
         end
      end

      // Hold the output while stalled, drop it once taken
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_SCAN;
         scan_ff          <= '0;
         count_ff         <= '0;
         overflow_seen_ff <= 1'b0;
         run_overflow_ff  <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         scan_ff          <= scan_in;
         count_ff         <= count_in;
         overflow_seen_ff <= overflow_seen_in;
         run_overflow_ff  <= run_overflow_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      rsp_char_ff       <= rsp_char_in;
      rsp_char_valid_ff <= rsp_char_valid_in;
      rsp_last_ff       <= rsp_last_in;
      rsp_overflow_ff   <= rsp_overflow_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_suffix_char    = rsp_char_ff;
   assign rsp_char_valid     = rsp_char_valid_ff;
   assign rsp_last_of_run    = rsp_last_ff;
   assign rsp_depth_overflow = rsp_overflow_ff;

endmodule

// File: rtl/core/dcs_stack_cell.sv
// One cell of the opener stack chain: holds a single opener code.
// Depends on dcs_pkg for the cell operation and code types.
`timescale 1ns / 1ps

module dcs_stack_cell (
   input  logic                    clock,
   input  dcs_pkg::cell_op_type    op,
   input  dcs_pkg::opener_code_type above_code,
   input  dcs_pkg::opener_code_type below_code,
   output dcs_pkg::opener_code_type code
);

   dcs_pkg::opener_code_type code_ff;
   dcs_pkg::opener_code_type code_in;

   // Take from the cell above on push, from the cell below on pop
   always_comb begin
      case (op)
         dcs_pkg::CELL_PUSH: code_in = above_code;
         dcs_pkg::CELL_POP:  code_in = below_code;
         default:            code_in = code_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
   end

   assign code = code_ff;

endmodule

// File: rtl/core/dcs_scan_ctrl.sv
// Scan-mode next-state logic: mode, pending flags and stack commands per byte.
// Depends on dcs_pkg for mode, state and command types.
`timescale 1ns / 1ps

module dcs_scan_ctrl (
   input  dcs_pkg::char_type        text_byte,
   input  dcs_pkg::scan_state_type  cur,
   input  dcs_pkg::count_type       stack_count,
   input  dcs_pkg::opener_code_type top_code,
   output dcs_pkg::scan_state_type  nxt,
   output dcs_pkg::stack_cmd_type   cmd
);

   logic stack_full;
   logic top_match;
   logic done;

   assign stack_full = (stack_count == dcs_pkg::CountWidth'(dcs_pkg::StackDepth));
   assign top_match  = (stack_count != '0) && (dcs_pkg::closer_of(top_code) == text_byte);

   always_comb begin
      nxt  = cur;
      cmd  = '0;
      done = 1'b0;
      unique case (cur.mode)
         dcs_pkg::MODE_CODE: begin
            // Resolve a pending slash first
            if (cur.pending_slash) begin
               nxt.pending_slash = 1'b0;
               if (text_byte == dcs_pkg::ChSlash) begin
                  nxt.mode = dcs_pkg::MODE_LINE;
                  done     = 1'b1;
               end else if (text_byte == dcs_pkg::ChStar) begin
                  nxt.mode         = dcs_pkg::MODE_BLOCK;
                  nxt.pending_star = 1'b0;
                  done             = 1'b1;
               end
            end
            if (!done) begin
               priority if (text_byte == dcs_pkg::ChQuote) begin
                  nxt.mode = dcs_pkg::MODE_STRING;
               end else if (text_byte == dcs_pkg::ChSlash) begin
                  nxt.pending_slash = 1'b1;
               end else if (text_byte == dcs_pkg::ChLBrace ||
                            text_byte == dcs_pkg::ChLBracket ||
                            text_byte == dcs_pkg::ChLParen) begin
                  // Push, or drop and flag when full
                  if (text_byte == dcs_pkg::ChLBrace) begin
                     cmd.code = dcs_pkg::OpenBrace;
                  end else if (text_byte == dcs_pkg::ChLBracket) begin
                     cmd.code = dcs_pkg::OpenBracket;
                  end else begin
                     cmd.code = dcs_pkg::OpenParen;
                  end
                  cmd.push     = !stack_full;
                  cmd.overflow = stack_full;
               end else if (text_byte == dcs_pkg::ChRBrace ||
                            text_byte == dcs_pkg::ChRBracket ||
                            text_byte == dcs_pkg::ChRParen) begin
                  // Pop only on a matching closer
                  cmd.pop = top_match;
               end else begin
                  cmd.pop = 1'b0;
               end
            end
         end
         dcs_pkg::MODE_STRING: begin
            if (cur.pending_escape) begin
               nxt.pending_escape = 1'b0;
            end else if (text_byte == dcs_pkg::ChBackslash) begin
               nxt.pending_escape = 1'b1;
            end else if (text_byte == dcs_pkg::ChQuote) begin
               nxt.mode = dcs_pkg::MODE_CODE;
            end
         end
         dcs_pkg::MODE_LINE: begin
            if (text_byte == dcs_pkg::ChNewline) begin
               nxt.mode = dcs_pkg::MODE_CODE;
            end
         end
         dcs_pkg::MODE_BLOCK: begin
            if (cur.pending_star && text_byte == dcs_pkg::ChSlash) begin
               nxt.pending_star = 1'b0;
               nxt.mode         = dcs_pkg::MODE_CODE;
            end else begin
               nxt.pending_star = (text_byte == dcs_pkg::ChStar);
            end
         end
      endcase
   end

endmodule
